// ===== src/pbd_pkg.sv =====
package pbd_pkg;

    localparam int MAX_DST = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_CHECK,
        ST_ROWBASE,
        ST_READ,
        ST_ACC,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        DV_TW,
        DV_SY0,
        DV_SY1,
        DV_SX0,
        DV_SX1,
        DV_RED,
        DV_GRN,
        DV_BLU,
        DV_ALP
    } div_op_t;

    localparam logic [1:0] CFG_SRC_W = 2'd0;
    localparam logic [1:0] CFG_SRC_H = 2'd1;
    localparam logic [1:0] CFG_TGT_H = 2'd2;

endpackage

// ===== src/pbd_div.sv =====
module pbd_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNTW = $clog2(W + 1);

    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic            done_reg;
    logic            done_next;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    quo_reg;
    logic [W-1:0]    dvs_reg;
    logic [W:0]      rem_shift;
    logic [W:0]      diff;
    logic            ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        ge        = !diff[W];
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CNTW'(W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[W-1:0] : rem_shift[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/pbd_store.sv =====
module pbd_store #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/premultiplied_box_downscale_unit.sv =====
// channel   direction  handshake            payload
// item in   input      start & !busy        kind, first, in_red/green/blue/alpha
// result    output     valid, one cycle     dst_x, dst_y, out_*, dst_width, last_pixel
// config    input      cfg_we               cfg_index, cfg_data
//
// A load leaves busy low.
// An emit keeps busy high while the shared restoring divider finds the destination
// width, the source box and, when the alpha sum is not zero, the channel values,
// and while the box texels are read one at a time from the store's read port; an
// emit that gives no result ends after the width division.
// Reset clears control state; store contents are undefined until loaded.
// valid is high for one cycle and cannot be held off by the receiver.
module premultiplied_box_downscale_unit #(
    parameter int MAX_SRC_W = 128,
    parameter int MAX_SRC_H = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       kind,
    input  logic       first,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_alpha,
    output logic       valid,
    output logic [5:0] dst_x,
    output logic [5:0] dst_y,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    output logic [6:0] dst_width,
    output logic       last_pixel,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW   = $clog2(DEPTH + 1);
    localparam int WW    = $clog2(MAX_SRC_W + 1);
    localparam int HW    = $clog2(MAX_SRC_H + 1);
    localparam int TW_W  = $clog2(pbd_pkg::MAX_DST + 1);
    localparam int CW    = $clog2(pbd_pkg::MAX_DST + 2);
    localparam int OPW0  = (WW > HW) ? WW : HW;
    localparam int OPW   = (OPW0 > CW) ? OPW0 : CW;
    localparam int ACC_W = AW + 17;
    localparam int AA_W  = AW + 9;
    localparam int DIV_W = (ACC_W > 2 * OPW) ? ACC_W : 2 * OPW;

    pbd_pkg::state_t  state_reg, state_next;
    pbd_pkg::div_op_t div_sel_reg, div_sel_next;

    logic [7:0]     sw_reg, sh_reg;
    logic [6:0]     th_cfg_reg;
    logic [LCW-1:0] load_count_reg, load_count_next;
    logic [CW-1:0]  cursor_x_reg, cursor_x_next;
    logic [CW-1:0]  cursor_y_reg, cursor_y_next;
    logic           image_done_reg, image_done_next;

    logic [TW_W-1:0]  tw_reg;
    logic [CW-1:0]    x_reg, y_reg;
    logic [HW-1:0]    sy0_reg, sy1_reg, sy_reg;
    logic [WW-1:0]    sx0_reg, sx1_reg, sx_reg;
    logic [AW-1:0]    row_base_reg;
    logic [ACC_W-1:0] ar_reg, ag_reg, ab_reg;
    logic [AA_W-1:0]  aa_reg;
    logic [LCW-1:0]   cnt_reg;
    logic [7:0]       red_reg, green_reg, blue_reg, alpha_reg;

    logic [WW-1:0]    w_c;
    logic [HW-1:0]    h_c;
    logic [TW_W-1:0]  th_c;
    logic             accept;
    logic [LCW-1:0]   count_eff;
    logic             store_we;
    logic [AW-1:0]    raddr;
    logic [31:0]      rdata;
    logic [OPW-1:0]   mul_a, mul_b;
    logic [2*OPW-1:0] prod;
    logic [DIV_W-1:0] div_dividend, div_divisor, div_quo;
    logic             div_start, div_done;
    logic [TW_W-1:0]  tw_q;
    logic [HW-1:0]    qh, sy0_inc;
    logic [WW-1:0]    qw, sx0_inc;
    logic [CW-1:0]    xs, ys, x_inc, y_inc;
    logic             x_over, last;
    logic             sx_last, sy_last;
    logic [7:0]       pr, pg, pb, pa;

    always_comb
    begin
        if (sw_reg == 8'd0)
            w_c = WW'(1);
        else if (32'(sw_reg) > 32'(MAX_SRC_W))
            w_c = WW'(MAX_SRC_W);
        else
            w_c = WW'(sw_reg);
        if (sh_reg == 8'd0)
            h_c = HW'(1);
        else if (32'(sh_reg) > 32'(MAX_SRC_H))
            h_c = HW'(MAX_SRC_H);
        else
            h_c = HW'(sh_reg);
        if (th_cfg_reg == 7'd0)
            th_c = TW_W'(1);
        else if (32'(th_cfg_reg) > 32'(pbd_pkg::MAX_DST))
            th_c = TW_W'(pbd_pkg::MAX_DST);
        else
            th_c = TW_W'(th_cfg_reg);
    end

    assign accept    = start && !busy;
    assign count_eff = first ? '0 : load_count_reg;
    assign store_we  = accept && !kind && (count_eff < LCW'(DEPTH));
    assign raddr     = row_base_reg + AW'(sx_reg);

    pbd_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .clk  (clk),
        .we   (store_we),
        .waddr(count_eff[AW-1:0]),
        .wdata({in_alpha, in_blue, in_green, in_red}),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == pbd_pkg::ST_ROWBASE)
        begin
            mul_a = OPW'(sy0_reg);
            mul_b = OPW'(w_c);
        end
        else
        begin
            case (div_sel_reg)
                pbd_pkg::DV_TW:
                begin
                    mul_a = OPW'(w_c);
                    mul_b = OPW'(th_c);
                end
                pbd_pkg::DV_SY0:
                begin
                    mul_a = OPW'(y_reg);
                    mul_b = OPW'(h_c);
                end
                pbd_pkg::DV_SY1:
                begin
                    mul_a = OPW'(y_inc);
                    mul_b = OPW'(h_c);
                end
                pbd_pkg::DV_SX0:
                begin
                    mul_a = OPW'(x_reg);
                    mul_b = OPW'(w_c);
                end
                pbd_pkg::DV_SX1:
                begin
                    mul_a = OPW'(x_inc);
                    mul_b = OPW'(w_c);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        case (div_sel_reg)
            pbd_pkg::DV_TW:
            begin
                div_dividend = DIV_W'(prod);
                div_divisor  = DIV_W'(h_c);
            end
            pbd_pkg::DV_SY0, pbd_pkg::DV_SY1:
            begin
                div_dividend = DIV_W'(prod);
                div_divisor  = DIV_W'(th_c);
            end
            pbd_pkg::DV_SX0, pbd_pkg::DV_SX1:
            begin
                div_dividend = DIV_W'(prod);
                div_divisor  = DIV_W'(tw_reg);
            end
            pbd_pkg::DV_RED:
            begin
                div_dividend = DIV_W'(ar_reg);
                div_divisor  = DIV_W'(aa_reg);
            end
            pbd_pkg::DV_GRN:
            begin
                div_dividend = DIV_W'(ag_reg);
                div_divisor  = DIV_W'(aa_reg);
            end
            pbd_pkg::DV_BLU:
            begin
                div_dividend = DIV_W'(ab_reg);
                div_divisor  = DIV_W'(aa_reg);
            end
            pbd_pkg::DV_ALP:
            begin
                div_dividend = DIV_W'(aa_reg);
                div_divisor  = DIV_W'(cnt_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = DIV_W'(1);
            end
        endcase
    end

    pbd_div #(
        .W(DIV_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quo)
    );

    always_comb
    begin
        if (div_quo == '0)
            tw_q = TW_W'(1);
        else if (div_quo > DIV_W'(pbd_pkg::MAX_DST))
            tw_q = TW_W'(pbd_pkg::MAX_DST);
        else
            tw_q = TW_W'(div_quo);
        qh      = HW'(div_quo);
        qw      = WW'(div_quo);
        sy0_inc = sy0_reg + 1'b1;
        sx0_inc = sx0_reg + 1'b1;
        x_over  = cursor_x_reg >= CW'(tw_reg);
        xs      = x_over ? '0 : cursor_x_reg;
        ys      = x_over ? cursor_y_reg + 1'b1 : cursor_y_reg;
        x_inc   = x_reg + 1'b1;
        y_inc   = y_reg + 1'b1;
        last    = (x_inc == CW'(tw_reg)) && (y_inc == CW'(th_c));
        sx_last = (sx_reg + 1'b1) == sx1_reg;
        sy_last = (sy_reg + 1'b1) == sy1_reg;
        pr      = rdata[7:0];
        pg      = rdata[15:8];
        pb      = rdata[23:16];
        pa      = rdata[31:24];
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        div_sel_next = div_sel_reg;
        case (state_reg)
            pbd_pkg::ST_IDLE:
            begin
                if (accept && kind)
                begin
                    div_sel_next = pbd_pkg::DV_TW;
                    state_next   = pbd_pkg::ST_DIV_GO;
                end
            end
            pbd_pkg::ST_DIV_GO:
            begin
                state_next = pbd_pkg::ST_DIV_WAIT;
            end
            pbd_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = pbd_pkg::ST_DIV_GO;
                    case (div_sel_reg)
                        pbd_pkg::DV_TW:  state_next   = pbd_pkg::ST_CHECK;
                        pbd_pkg::DV_SY0: div_sel_next = pbd_pkg::DV_SY1;
                        pbd_pkg::DV_SY1: div_sel_next = pbd_pkg::DV_SX0;
                        pbd_pkg::DV_SX0: div_sel_next = pbd_pkg::DV_SX1;
                        pbd_pkg::DV_SX1: state_next   = pbd_pkg::ST_ROWBASE;
                        pbd_pkg::DV_RED: div_sel_next = pbd_pkg::DV_GRN;
                        pbd_pkg::DV_GRN: div_sel_next = pbd_pkg::DV_BLU;
                        pbd_pkg::DV_BLU: div_sel_next = pbd_pkg::DV_ALP;
                        pbd_pkg::DV_ALP: state_next   = pbd_pkg::ST_OUT;
                        default:         state_next   = pbd_pkg::ST_IDLE;
                    endcase
                end
            end
            pbd_pkg::ST_CHECK:
            begin
                if (image_done_reg || (ys >= CW'(th_c)))
                begin
                    state_next = pbd_pkg::ST_IDLE;
                end
                else
                begin
                    div_sel_next = pbd_pkg::DV_SY0;
                    state_next   = pbd_pkg::ST_DIV_GO;
                end
            end
            pbd_pkg::ST_ROWBASE:
            begin
                state_next = pbd_pkg::ST_READ;
            end
            pbd_pkg::ST_READ:
            begin
                state_next = pbd_pkg::ST_ACC;
            end
            pbd_pkg::ST_ACC:
            begin
                state_next = (sx_last && sy_last) ? pbd_pkg::ST_FIN : pbd_pkg::ST_READ;
            end
            pbd_pkg::ST_FIN:
            begin
                if (aa_reg == '0)
                begin
                    state_next = pbd_pkg::ST_OUT;
                end
                else
                begin
                    div_sel_next = pbd_pkg::DV_RED;
                    state_next   = pbd_pkg::ST_DIV_GO;
                end
            end
            pbd_pkg::ST_OUT:
            begin
                state_next = pbd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pbd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = state_reg != pbd_pkg::ST_IDLE;
        div_start = state_reg == pbd_pkg::ST_DIV_GO;
        valid     = state_reg == pbd_pkg::ST_OUT;
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        image_done_next = image_done_reg;
        if (accept)
        begin
            if (first)
            begin
                load_count_next = '0;
                cursor_x_next   = '0;
                cursor_y_next   = '0;
                image_done_next = 1'b0;
            end
            if (store_we)
            begin
                load_count_next = count_eff + 1'b1;
            end
        end
        if ((state_reg == pbd_pkg::ST_CHECK) && !image_done_reg)
        begin
            cursor_x_next = xs;
            cursor_y_next = ys;
            if (ys >= CW'(th_c))
            begin
                image_done_next = 1'b1;
            end
        end
        if (state_reg == pbd_pkg::ST_OUT)
        begin
            if (last)
            begin
                image_done_next = 1'b1;
            end
            else if (x_inc >= CW'(tw_reg))
            begin
                cursor_x_next = '0;
                cursor_y_next = y_inc;
            end
            else
            begin
                cursor_x_next = x_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pbd_pkg::ST_IDLE;
            div_sel_reg    <= pbd_pkg::DV_TW;
            sw_reg         <= 8'd1;
            sh_reg         <= 8'd1;
            th_cfg_reg     <= 7'd32;
            load_count_reg <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            image_done_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            div_sel_reg    <= div_sel_next;
            load_count_reg <= load_count_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            image_done_reg <= image_done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    pbd_pkg::CFG_SRC_W: sw_reg     <= cfg_data;
                    pbd_pkg::CFG_SRC_H: sh_reg     <= cfg_data;
                    pbd_pkg::CFG_TGT_H: th_cfg_reg <= cfg_data[6:0];
                    default:            sw_reg     <= sw_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            pbd_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (div_sel_reg)
                        pbd_pkg::DV_TW:  tw_reg    <= tw_q;
                        pbd_pkg::DV_SY0: sy0_reg   <= qh;
                        pbd_pkg::DV_SY1: sy1_reg   <= (qh < sy0_inc) ? sy0_inc : qh;
                        pbd_pkg::DV_SX0: sx0_reg   <= qw;
                        pbd_pkg::DV_SX1: sx1_reg   <= (qw < sx0_inc) ? sx0_inc : qw;
                        pbd_pkg::DV_RED: red_reg   <= div_quo[7:0];
                        pbd_pkg::DV_GRN: green_reg <= div_quo[7:0];
                        pbd_pkg::DV_BLU: blue_reg  <= div_quo[7:0];
                        pbd_pkg::DV_ALP: alpha_reg <= div_quo[7:0];
                        default:         tw_reg    <= tw_reg;
                    endcase
                end
            end
            pbd_pkg::ST_CHECK:
            begin
                x_reg <= xs;
                y_reg <= ys;
            end
            pbd_pkg::ST_ROWBASE:
            begin
                row_base_reg <= AW'(prod);
                sy_reg       <= sy0_reg;
                sx_reg       <= sx0_reg;
                ar_reg       <= '0;
                ag_reg       <= '0;
                ab_reg       <= '0;
                aa_reg       <= '0;
                cnt_reg      <= '0;
            end
            pbd_pkg::ST_ACC:
            begin
                ar_reg  <= ar_reg + ACC_W'(pr * pa);
                ag_reg  <= ag_reg + ACC_W'(pg * pa);
                ab_reg  <= ab_reg + ACC_W'(pb * pa);
                aa_reg  <= aa_reg + AA_W'(pa);
                cnt_reg <= cnt_reg + 1'b1;
                if (sx_last)
                begin
                    sx_reg       <= sx0_reg;
                    sy_reg       <= sy_reg + 1'b1;
                    row_base_reg <= row_base_reg + AW'(w_c);
                end
                else
                begin
                    sx_reg <= sx_reg + 1'b1;
                end
            end
            pbd_pkg::ST_FIN:
            begin
                if (aa_reg == '0)
                begin
                    red_reg   <= 8'd0;
                    green_reg <= 8'd0;
                    blue_reg  <= 8'd0;
                    alpha_reg <= 8'd0;
                end
            end
            default:
            begin
                tw_reg <= tw_reg;
            end
        endcase
    end

    assign dst_x      = 6'(x_reg);
    assign dst_y      = 6'(y_reg);
    assign out_red    = red_reg;
    assign out_green  = green_reg;
    assign out_blue   = blue_reg;
    assign out_alpha  = alpha_reg;
    assign dst_width  = 7'(tw_reg);
    assign last_pixel = last;

`ifndef SYNTH
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind) |=> busy)
        else $error("emit item did not start the sequencer");

    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !busy)
        else $error("sequencer did not return to idle after a result");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == pbd_pkg::ST_DIV_WAIT))
        else $error("divider finished outside a wait state");

    a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (dst_width != 7'd0))
        else $error("destination width is zero on a result");
`endif

endmodule

// ===== dv/premultiplied_box_downscale_unit_test.sv =====
module premultiplied_box_downscale_unit_test;

    localparam int STORE_DEPTH = 128 * 128;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EMIT = 1'b1;

    typedef struct packed {
        logic       kind;
        logic       first;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } request_t;

    typedef struct packed {
        logic [5:0] x;
        logic [5:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [6:0] width;
        logic       last;
    } pixel_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       kind;
    logic       first;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic       valid;
    logic [5:0] dst_x;
    logic [5:0] dst_y;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic [6:0] dst_width;
    logic       last_pixel;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    premultiplied_box_downscale_unit u_dut (.*);

    // scaler mirror state
    logic [31:0] frame_mem [STORE_DEPTH];
    int          loaded;
    int          cur_x;
    int          cur_y;
    bit          frame_done;
    int          reg_w;
    int          reg_h;
    int          reg_th;

    request_t    pending_requests[$];
    pixel_t      expected_pixels[$];
    request_t    held;
    int          send_idle_pct;
    int          quiet_cycles;
    bit          failed;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int clamp_to(int v, int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int dest_width();
        return clamp_to((clamp_to(reg_w, 128) * clamp_to(reg_th, 64)) / clamp_to(reg_h, 128), 64);
    endfunction

    task automatic downscale_request(request_t r);
        int w, h, th, tw, sy0, sy1, sx0, sx1;
        longint sr, sg, sb, sa, cnt;
        logic [31:0] p;
        pixel_t px;
        if (r.first)
        begin
            loaded = 0;
            cur_x = 0;
            cur_y = 0;
            frame_done = 0;
        end
        if (r.kind == KIND_LOAD)
        begin
            if (loaded < STORE_DEPTH)
            begin
                frame_mem[loaded] = {r.alpha, r.blue, r.green, r.red};
                loaded++;
            end
            return;
        end
        w = clamp_to(reg_w, 128);
        h = clamp_to(reg_h, 128);
        th = clamp_to(reg_th, 64);
        tw = dest_width();
        if (frame_done)
            return;
        if (cur_x >= tw)
        begin
            cur_x = 0;
            cur_y++;
        end
        if (cur_y >= th)
        begin
            frame_done = 1;
            return;
        end
        sy0 = cur_y * h / th;
        sy1 = (cur_y + 1) * h / th;
        if (sy1 < sy0 + 1)
            sy1 = sy0 + 1;
        sx0 = cur_x * w / tw;
        sx1 = (cur_x + 1) * w / tw;
        if (sx1 < sx0 + 1)
            sx1 = sx0 + 1;
        sr = 0; sg = 0; sb = 0; sa = 0; cnt = 0;
        for (int sy = sy0; sy < sy1 && sy < h; sy++)
            for (int sx = sx0; sx < sx1 && sx < w; sx++)
            begin
                p = frame_mem[sy * w + sx];
                sr += p[7:0] * p[31:24];
                sg += p[15:8] * p[31:24];
                sb += p[23:16] * p[31:24];
                sa += p[31:24];
                cnt++;
            end
        px = '0;
        if (sa != 0)
        begin
            px.red = 8'(sr / sa);
            px.green = 8'(sg / sa);
            px.blue = 8'(sb / sa);
            px.alpha = 8'(sa / cnt);
        end
        px.x = 6'(cur_x);
        px.y = 6'(cur_y);
        px.width = 7'(tw);
        px.last = (cur_x + 1 == tw) && (cur_y + 1 == th);
        expected_pixels = {expected_pixels, px};
        if (px.last)
            frame_done = 1;
        else
        begin
            cur_x++;
            if (cur_x >= tw)
            begin
                cur_x = 0;
                cur_y++;
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            {kind, first, in_red, in_green, in_blue, in_alpha} <= '0;
        end
        else if (!start || !busy)
        begin
            if (start)
                downscale_request(held);
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                held = pending_requests.pop_front();
                start <= 1'b1;
                kind <= held.kind;
                first <= held.first;
                in_red <= held.red;
                in_green <= held.green;
                in_blue <= held.blue;
                in_alpha <= held.alpha;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pixel_t exp_px;
        pixel_t got;
        if (rst_n && valid)
        begin
            got = {dst_x, dst_y, out_red, out_green, out_blue, out_alpha, dst_width, last_pixel};
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel %h", $time, got);
                failed = 1;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (exp_px.x !== got.x)
                    $display("%0t: dst_x exp %0d got %0d", $time, exp_px.x, got.x);
                if (exp_px.y !== got.y)
                    $display("%0t: dst_y exp %0d got %0d", $time, exp_px.y, got.y);
                if (exp_px.red !== got.red)
                    $display("%0t: out_red exp %0d got %0d", $time, exp_px.red, got.red);
                if (exp_px.green !== got.green)
                    $display("%0t: out_green exp %0d got %0d", $time, exp_px.green, got.green);
                if (exp_px.blue !== got.blue)
                    $display("%0t: out_blue exp %0d got %0d", $time, exp_px.blue, got.blue);
                if (exp_px.alpha !== got.alpha)
                    $display("%0t: out_alpha exp %0d got %0d", $time, exp_px.alpha, got.alpha);
                if (exp_px.width !== got.width)
                    $display("%0t: dst_width exp %0d got %0d", $time, exp_px.width, got.width);
                if (exp_px.last !== got.last)
                    $display("%0t: last_pixel exp %0d got %0d", $time, exp_px.last, got.last);
                if (exp_px !== got)
                    failed = 1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || valid || (start && !busy) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("premultiplied_box_downscale_unit_test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            pbd_pkg::CFG_SRC_W: reg_w = int'(val);
            pbd_pkg::CFG_SRC_H: reg_h = int'(val);
            default:            reg_th = int'(val[6:0]);
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(logic [7:0] w, logic [7:0] h, logic [6:0] th);
        write_reg(pbd_pkg::CFG_SRC_W, w);
        write_reg(pbd_pkg::CFG_SRC_H, h);
        write_reg(pbd_pkg::CFG_TGT_H, {1'b0, th});
    endtask

    task automatic wait_drained();
        int calm;
        calm = 0;
        while (calm < 4)
        begin
            @(posedge clk);
            if (pending_requests.size() == 0 && !start && !busy && expected_pixels.size() == 0)
                calm++;
            else
                calm = 0;
        end
    endtask

    function automatic request_t random_pixel(bit is_first);
        request_t r;
        r.kind = KIND_LOAD;
        r.first = is_first;
        r.red = 8'($urandom);
        r.green = 8'($urandom);
        r.blue = 8'($urandom);
        case ($urandom_range(5))
            0:       r.alpha = 8'd0;
            1:       r.alpha = 8'd255;
            default: r.alpha = 8'($urandom);
        endcase
        return r;
    endfunction

    task automatic queue_emits(int n, bit first_on_one);
        request_t r;
        for (int i = 0; i < n; i++)
        begin
            r = random_pixel(0);
            r.kind = KIND_EMIT;
            r.first = first_on_one && (i == 0);
            pending_requests = {pending_requests, r};
        end
    endtask

    // loads a full frame for the current geometry, then n emits
    task automatic queue_frame(int n_emits);
        int npix;
        npix = clamp_to(reg_w, 128) * clamp_to(reg_h, 128);
        for (int i = 0; i < npix; i++)
            pending_requests = {pending_requests, random_pixel(i == 0)};
        queue_emits(n_emits, 0);
    endtask

    initial begin
        int total;
        int tw;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        failed = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        loaded = 0;
        cur_x = 0;
        cur_y = 0;
        frame_done = 0;
        reg_w = 1;
        reg_h = 1;
        reg_th = 32;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: 1x1 source into 32 rows, plus emits past the end
        queue_frame(dest_width() * 32 + 2);
        wait_drained();

        // wide source saturating dst width at 64
        set_geometry(8'd128, 8'd1, 7'd1);
        queue_frame(66);
        wait_drained();

        // out-of-range registers: zeros act as one
        set_geometry(8'd0, 8'd0, 7'd0);
        queue_frame(3);
        wait_drained();

        // oversized registers clamp to the limits
        set_geometry(8'd255, 8'd1, 7'd2);
        queue_frame(3);
        wait_drained();
        set_geometry(8'd1, 8'd200, 7'd127);
        queue_frame(65);
        wait_drained();

        // width shrinks mid-frame so the cursor lands past the new width
        set_geometry(8'd8, 8'd4, 7'd4);
        queue_frame(7);
        wait_drained();
        write_reg(pbd_pkg::CFG_SRC_W, 8'd3);
        queue_emits(20, 0);
        wait_drained();

        total = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 77 : 0;
            while (total < (ph + 1) * 370)
            begin
                case ($urandom_range(9))
                    0:       set_geometry(8'($urandom_range(0, 255)), 8'($urandom_range(1, 6)),
                                          7'($urandom_range(0, 127)));
                    default: set_geometry(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                                          7'($urandom_range(1, 8)));
                endcase
                tw = dest_width();
                if (clamp_to(reg_w, 128) * clamp_to(reg_h, 128) > 200)
                    set_geometry(8'(reg_w), 8'd1, 7'd1);
                tw = dest_width();
                total += clamp_to(reg_w, 128) * clamp_to(reg_h, 128);
                if (tw * clamp_to(reg_th, 64) > 40)
                    write_reg(pbd_pkg::CFG_TGT_H, 8'd1);
                tw = dest_width();
                queue_frame(tw * clamp_to(reg_th, 64) + $urandom_range(0, 2));
                if ($urandom_range(3) == 0)
                    queue_emits($urandom_range(1, 4), 1);
                total += tw * clamp_to(reg_th, 64);
                wait_drained();
            end
        end

        repeat (50) @(posedge clk);
        if (!failed && expected_pixels.size() == 0)
            $display("premultiplied_box_downscale_unit_test passed");
        else
            $display("premultiplied_box_downscale_unit_test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
src/pbd_pkg.sv
src/pbd_div.sv
src/pbd_store.sv
src/premultiplied_box_downscale_unit.sv
dv/premultiplied_box_downscale_unit_test.sv
